// ===== sv/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, status codes and operation codes of the task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int unsigned TASK_SLOTS_DEF = 32;
  localparam int unsigned SLOT_W         = 5;
  localparam int unsigned STAT_W         = 3;

  typedef logic [STAT_W-1:0] stat_t;

  localparam stat_t ST_RUNNING = 3'd0;
  localparam stat_t ST_READY   = 3'd1;
  localparam stat_t ST_BLOCKED = 3'd2;
  localparam stat_t ST_WAITING = 3'd3;
  localparam stat_t ST_HANGING = 3'd4;
  localparam stat_t ST_DIED    = 3'd5;

  localparam logic [2:0] FN_CREATE  = 3'd0;
  localparam logic [2:0] FN_YIELD   = 3'd1;
  localparam logic [2:0] FN_BLOCK   = 3'd2;
  localparam logic [2:0] FN_UNBLOCK = 3'd3;
  localparam logic [2:0] FN_EXIT    = 3'd4;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_UNBLOCK = 2'd1;
  localparam logic [1:0] ERR_CREATE  = 2'd2;

  // Command broadcast along the cell chain
  typedef struct packed {
    logic              wr;
    logic [SLOT_W-1:0] slot;
    stat_t             status;
  } cell_cmd_t;

  // Data passing from cell to cell: status found at the watched slot
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    stat_t             status;
  } cell_bus_t;

endpackage

// ===== sv/rrts_cell.sv =====
// ----------------------------------------------------------------------------
// rrts_cell
// One task slot: holds its status and passes the lookup bus onward.
// ----------------------------------------------------------------------------
module rrts_cell #(
  parameter int unsigned IDX = 0,
  parameter logic [rrts_pkg::STAT_W-1:0] RST_ST = rrts_pkg::ST_DIED
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rrts_pkg::cell_cmd_t cmd,
  input  rrts_pkg::cell_bus_t bus_in,
  output rrts_pkg::cell_bus_t bus_out
);

  rrts_pkg::stat_t st_r;
  rrts_pkg::stat_t st_nxt;

  always_comb begin
    st_nxt = st_r;
    if (cmd.wr && cmd.slot == rrts_pkg::SLOT_W'(IDX)) begin
      st_nxt = cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= RST_ST;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    bus_out = bus_in;
    if (bus_in.slot == rrts_pkg::SLOT_W'(IDX)) begin
      bus_out.status = st_r;
    end
  end

endmodule

// ===== sv/rrts_chain.sv =====
// ----------------------------------------------------------------------------
// rrts_chain
// Row of slot cells; the lookup bus is registered after the last cell.
// ----------------------------------------------------------------------------
module rrts_chain #(
  parameter int unsigned TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rrts_pkg::cell_cmd_t            cmd,
  input  logic [rrts_pkg::SLOT_W-1:0]    look_slot,
  output rrts_pkg::stat_t                look_status
);

  rrts_pkg::cell_bus_t bus [TASK_SLOTS+1];
  rrts_pkg::cell_bus_t res_r;

  assign bus[0].slot   = look_slot;
  assign bus[0].status = rrts_pkg::ST_DIED;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    localparam rrts_pkg::stat_t RS = (i == 0) ? rrts_pkg::ST_RUNNING :
                                     (i == 1) ? rrts_pkg::ST_BLOCKED :
                                                rrts_pkg::ST_DIED;
    rrts_cell #(.IDX(i), .RST_ST(RS)) u_cell (
      .clk(clk), .rst_n(rst_n), .cmd(cmd),
      .bus_in(bus[i]), .bus_out(bus[i+1])
    );
  end

  always_ff @(posedge clk) begin
    res_r <= bus[TASK_SLOTS];
  end

  assign look_status = res_r.status;

endmodule

// ===== sv/round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin ready deque over task slots held in a chain of status cells.
// ----------------------------------------------------------------------------
// channel | ports                                          | direction
// input   | start, busy, in_func/target_slot/block_kind/.. | in, busy out
// result  | out_valid, out_running_slot/switched/error_code| out
// config  | cfg_we, cfg_idle_slot                          | in
// In each transaction every status lookup passes through the cell chain and a
// result register, and each link array takes at most one write per cycle.
// Reset is synchronous; the result strobe lasts one cycle; busy holds from
// accept until the strobe cycle ends. The receiver cannot stall.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler #(
  parameter int unsigned TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_func,
  input  logic [4:0] in_target_slot,
  input  logic [1:0] in_block_kind,
  input  logic       in_dispatch_after,
  input  logic       cfg_we,
  input  logic [4:0] cfg_idle_slot,
  output logic       out_valid,
  output logic [4:0] out_running_slot,
  output logic       out_switched,
  output logic [1:0] out_error_code
);

  localparam int unsigned SW = rrts_pkg::SLOT_W;
  localparam logic [SW-1:0] SMAX = SW'(TASK_SLOTS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LK1   = 4'd1;  // target status lookup
  localparam logic [3:0] S_LK2   = 4'd2;
  localparam logic [3:0] S_OP    = 4'd3;  // target op, may write links
  localparam logic [3:0] S_RM    = 4'd4;  // unlink target
  localparam logic [3:0] S_DC1   = 4'd5;  // current status lookup
  localparam logic [3:0] S_DC2   = 4'd6;
  localparam logic [3:0] S_DAPP  = 4'd7;  // requeue or block current
  localparam logic [3:0] S_DPOP  = 4'd8;  // pop head as running
  localparam logic [3:0] S_DRM   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [SW-1:0] idle_r;
  logic [SW-1:0] head_r, head_nxt, tail_r, tail_nxt, cur_r, cur_nxt;
  logic [SW:0]   cnt_r, cnt_nxt;
  logic [2:0]    func_r;
  logic [SW-1:0] tgt_r;
  logic          tgt_ok_r;
  logic [1:0]    kind_r;
  logic          after_r;
  logic          sw_r, sw_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [SW-1:0] rm_r, rm_nxt;        // slot being unlinked
  logic [SW-1:0] nl [TASK_SLOTS];
  logic [SW-1:0] pl [TASK_SLOTS];

  rrts_pkg::cell_cmd_t cmd;
  logic [SW-1:0]       look_slot;
  rrts_pkg::stat_t     look_status;

  // link write requests (one each per cycle)
  logic          nl_we, pl_we;
  logic [SW-1:0] nl_a, nl_d, pl_a, pl_d;

  rrts_chain #(.TASK_SLOTS(TASK_SLOTS)) u_chain (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .look_slot(look_slot), .look_status(look_status)
  );

  function automatic logic [SW-1:0] clip(input logic [SW-1:0] v);
    return (v <= SMAX) ? v : '0;
  endfunction

  logic [SW-1:0] rm_p, rm_n;
  assign rm_p = clip(pl[rm_r]);
  assign rm_n = clip(nl[rm_r]);

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    sw_nxt    = sw_r;
    err_nxt   = err_r;
    rm_nxt    = rm_r;
    cmd       = '{wr: 1'b0, slot: '0, status: rrts_pkg::ST_DIED};
    look_slot = tgt_r;
    nl_we = 1'b0; nl_a = '0; nl_d = '0;
    pl_we = 1'b0; pl_a = '0; pl_d = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_LK1;
          sw_nxt    = 1'b0;
          err_nxt   = rrts_pkg::ERR_OK;
        end
      end
      S_LK1: begin
        state_nxt = S_LK2;
      end
      S_LK2: begin
        state_nxt = S_OP;
      end
      S_OP: begin
        state_nxt = S_OUT;
        case (func_r)
          rrts_pkg::FN_CREATE: begin
            if (tgt_ok_r && look_status == rrts_pkg::ST_DIED) begin
              cmd = '{wr: 1'b1, slot: tgt_r, status: rrts_pkg::ST_READY};
              pl_we = 1'b1; pl_a = tgt_r; pl_d = tail_r;
              if (cnt_r == '0) head_nxt = tgt_r;
              else begin
                nl_we = 1'b1; nl_a = clip(tail_r); nl_d = tgt_r;
              end
              tail_nxt = tgt_r;
              cnt_nxt  = cnt_r + 1'b1;
            end else begin
              err_nxt = rrts_pkg::ERR_CREATE;
            end
          end
          rrts_pkg::FN_YIELD: state_nxt = S_DC1;
          rrts_pkg::FN_BLOCK: state_nxt = S_DC1;
          rrts_pkg::FN_UNBLOCK: begin
            if (tgt_ok_r && (look_status == rrts_pkg::ST_BLOCKED ||
                look_status == rrts_pkg::ST_WAITING ||
                look_status == rrts_pkg::ST_HANGING)) begin
              cmd = '{wr: 1'b1, slot: tgt_r, status: rrts_pkg::ST_READY};
              nl_we = 1'b1; nl_a = tgt_r; nl_d = head_r;
              if (cnt_r == '0) tail_nxt = tgt_r;
              else begin
                pl_we = 1'b1; pl_a = clip(head_r); pl_d = tgt_r;
              end
              head_nxt = tgt_r;
              cnt_nxt  = cnt_r + 1'b1;
            end else begin
              err_nxt = rrts_pkg::ERR_UNBLOCK;
            end
          end
          rrts_pkg::FN_EXIT: begin
            if (tgt_ok_r) begin
              cmd = '{wr: 1'b1, slot: tgt_r, status: rrts_pkg::ST_DIED};
            end
            if (tgt_ok_r && look_status == rrts_pkg::ST_READY) begin
              rm_nxt    = tgt_r;
              state_nxt = S_RM;
            end else if (after_r) begin
              state_nxt = S_DC1;
            end
          end
          default: ;
        endcase
      end
      S_RM, S_DRM: begin
        if (cnt_r != '0) begin
          if (rm_r == head_r) head_nxt = rm_n;
          else begin
            nl_we = 1'b1; nl_a = rm_p; nl_d = rm_n;
          end
          if (rm_r == tail_r) tail_nxt = rm_p;
          else begin
            pl_we = 1'b1; pl_a = rm_n; pl_d = rm_p;
          end
          cnt_nxt = cnt_r - 1'b1;
        end
        state_nxt = (state_r == S_RM && after_r) ? S_DC1 : S_OUT;
      end
      S_DC1: begin
        look_slot = cur_r;
        state_nxt = S_DC2;
        sw_nxt    = 1'b1;
      end
      S_DC2: begin
        look_slot = cur_r;
        state_nxt = S_DAPP;
      end
      S_DAPP: begin
        state_nxt = S_DPOP;
        if (look_status == rrts_pkg::ST_RUNNING) begin
          cmd = '{wr: 1'b1, slot: cur_r, status: rrts_pkg::ST_READY};
          if (func_r == rrts_pkg::FN_BLOCK) begin
            cmd.status = (kind_r >= 2'd2) ? rrts_pkg::ST_HANGING :
                         rrts_pkg::stat_t'(rrts_pkg::ST_BLOCKED + kind_r);
          end else begin
            pl_we = 1'b1; pl_a = cur_r; pl_d = tail_r;
            if (cnt_r == '0) head_nxt = cur_r;
            else begin
              nl_we = 1'b1; nl_a = clip(tail_r); nl_d = cur_r;
            end
            tail_nxt = cur_r;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
      end
      S_DPOP: begin
        if (cnt_r == '0) begin
          cur_nxt   = clip(idle_r);
          state_nxt = S_OUT;
        end else begin
          cur_nxt   = clip(head_r);
          rm_nxt    = clip(head_r);
          state_nxt = S_DRM;
        end
        cmd = '{wr: 1'b1, slot: cur_nxt, status: rrts_pkg::ST_RUNNING};
      end
      S_OUT: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idle_r  <= SW'(1);
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      cur_r   <= '0;
      sw_r    <= 1'b0;
      err_r   <= rrts_pkg::ERR_OK;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      sw_r    <= sw_nxt;
      err_r   <= err_nxt;
      if (cfg_we) idle_r <= cfg_idle_slot;
    end
  end

  always_ff @(posedge clk) begin
    rm_r <= rm_nxt;
    if (state_r == S_IDLE && start) begin
      func_r   <= in_func;
      tgt_r    <= clip(in_target_slot);
      tgt_ok_r <= in_target_slot <= SMAX;
      kind_r   <= in_block_kind;
      after_r  <= in_dispatch_after;
    end
    if (nl_we) nl[nl_a] <= nl_d;
    if (pl_we) pl[pl_a] <= pl_d;
  end

  assign busy             = state_r != S_IDLE;
  assign out_valid        = state_r == S_OUT;
  assign out_running_slot = cur_r;
  assign out_switched     = sw_r;
  assign out_error_code   = err_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (SW+1)'(TASK_SLOTS)) else $error("queue count overflow");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result strobe");
  a_sw_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switched |-> out_error_code == rrts_pkg::ERR_OK)
    else $error("switch with error");
`endif

endmodule
